[design/type7_command_stream_validator_unit_assert.svh]
// Assertion macros shared by the checker of the type-7 stream validator.
// Depends on nothing; the including scope provides clock and reset.
`ifndef TYPE7_COMMAND_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define TYPE7_COMMAND_STREAM_VALIDATOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define T7CSV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define T7CSV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/t7csv_pkg.sv]
// Constants, status codes and helper functions of the type-7 stream validator.
// Depends on nothing; used by the interfaces, the top level and the checker.
package t7csv_pkg;

   // Field widths.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned COUNT_W  = 21;
   localparam int unsigned LEN_W    = 14;
   localparam int unsigned OP_W     = 7;
   localparam int unsigned STATUS_W = 2;

   // Counter bound: the configured limit, clipped to what the field holds.
   localparam longint unsigned MAX_STREAM_WORDS = 64'd1048576;
   localparam longint unsigned FIELD21_MAX      = 64'h1f_ffff;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((MAX_STREAM_WORDS < FIELD21_MAX) ? MAX_STREAM_WORDS : FIELD21_MAX);

   // Header layout.
   localparam logic [3:0]      HDR_TYPE_VALUE = 4'h7;
   localparam logic [3:0]      HDR_RSVD_VALUE = 4'h0;
   localparam logic [OP_W-1:0] OP_NOP         = 7'h10;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERRUN    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OPCODE = 2'd3;

   // Odd parity bit: one when the value has an even number of ones.
   function automatic logic odd_parity(input logic [LEN_W-1:0] v);
      return ~(^v);
   endfunction

   // Increment that stops at the counter bound.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v < COUNT_LIMIT) ? v + COUNT_W'(1) : COUNT_LIMIT;
   endfunction

endpackage

[design/t7csv_stream_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on t7csv_pkg for field widths.
interface t7csv_req_if
   import t7csv_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   cmd_word;
   logic                end_of_stream;

   modport source (output valid, output cmd_word, output end_of_stream, input ready);
   modport sink   (input valid, input cmd_word, input end_of_stream, output ready);
endinterface

interface t7csv_rsp_if
   import t7csv_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  packet_count;
   logic [COUNT_W-1:0]  word_count;

   modport source (output valid, output status, output packet_count, output word_count,
                   input ready);
   modport sink   (input valid, input status, input packet_count, input word_count,
                   output ready);
endinterface

[design/type7_command_stream_validator_unit.sv]
// A final word's response passes through the input register and then the result register.
// Throughput: one request per cycle; the checks and counter update run between
// the input register and the result register.
// Only a final word waits, and only while an earlier result is still untaken.
// Reset is synchronous and active high; it clears the counters, the fault state
// and both valid flags.
module type7_command_stream_validator_unit
   import t7csv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   t7csv_req_if.sink    req_ch,
   t7csv_rsp_if.source  rsp_ch
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_eos_ff;

   // Stream state.
   logic [LEN_W-1:0]    payload_left_ff, payload_left_in;
   logic [COUNT_W-1:0]  packets_seen_ff, packets_seen_in;
   logic [COUNT_W-1:0]  words_seen_ff, words_seen_in;
   logic [STATUS_W-1:0] fault_code_ff, fault_code_in;
   logic                op_pending_ff, op_pending_in;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [COUNT_W-1:0]  out_packets_ff;
   logic [COUNT_W-1:0]  out_words_ff;

   logic                out_free;
   logic                proc_fire;
   logic                hdr_ok;
   logic [OP_W-1:0]     hdr_op;
   logic [LEN_W-1:0]    hdr_cnt;
   logic [STATUS_W-1:0] result_status;

   // Handshake: a word leaves the input register unless it is final and the
   // result register is still occupied.
   assign out_free    = !out_valid_ff || rsp_ch.ready;
   assign proc_fire   = in_valid_ff && (!in_eos_ff || out_free);
   assign req_ch.ready = !in_valid_ff || proc_fire;

   always_comb begin
      priority if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Header decode and checks.
   assign hdr_op  = in_word_ff[22:16];
   assign hdr_cnt = in_word_ff[13:0];
   assign hdr_ok  = (in_word_ff[31:28] == HDR_TYPE_VALUE) &&
                    (in_word_ff[27:24] == HDR_RSVD_VALUE) &&
                    (in_word_ff[23] == odd_parity(LEN_W'(hdr_op))) &&
                    (in_word_ff[15] == odd_parity(hdr_cnt));

   // State update for one word; nothing changes once a fault is recorded.
   always_comb begin
      payload_left_in = payload_left_ff;
      packets_seen_in = packets_seen_ff;
      words_seen_in   = words_seen_ff;
      fault_code_in   = fault_code_ff;
      op_pending_in   = op_pending_ff;
      if (fault_code_ff == STATUS_OK) begin
         words_seen_in = sat_inc(words_seen_ff);
         priority if (payload_left_ff != '0) begin
            payload_left_in = payload_left_ff - LEN_W'(1);
            if (payload_left_ff == LEN_W'(1) && op_pending_ff) begin
               fault_code_in = STATUS_BAD_OPCODE;
               op_pending_in = 1'b0;
            end
         end else if (!hdr_ok) begin
            fault_code_in = STATUS_BAD_HEADER;
         end else begin
            payload_left_in = hdr_cnt;
            if (hdr_op != OP_NOP) begin
               if (hdr_cnt == '0) begin
                  fault_code_in = STATUS_BAD_OPCODE;
               end else begin
                  op_pending_in = 1'b1;
               end
            end else begin
               packets_seen_in = sat_inc(packets_seen_ff);
            end
         end
      end
   end

   // A fault-free stream that ends with payload still owed is an overrun.
   always_comb begin
      result_status = fault_code_in;
      if (fault_code_in == STATUS_OK && payload_left_in != '0) begin
         result_status = STATUS_OVERRUN;
      end
   end

   // The result register fills on a final word and drains on the response side.
   always_comb begin
      priority if (proc_fire && in_eos_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         payload_left_ff <= '0;
         packets_seen_ff <= '0;
         words_seen_ff   <= '0;
         fault_code_ff   <= STATUS_OK;
         op_pending_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc_fire) begin
            if (in_eos_ff) begin
               payload_left_ff <= '0;
               packets_seen_ff <= '0;
               words_seen_ff   <= '0;
               fault_code_ff   <= STATUS_OK;
               op_pending_ff   <= 1'b0;
            end else begin
               payload_left_ff <= payload_left_in;
               packets_seen_ff <= packets_seen_in;
               words_seen_ff   <= words_seen_in;
               fault_code_ff   <= fault_code_in;
               op_pending_ff   <= op_pending_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_word_ff <= req_ch.cmd_word;
         in_eos_ff  <= req_ch.end_of_stream;
      end
      if (proc_fire && in_eos_ff) begin
         out_status_ff  <= result_status;
         out_packets_ff <= (result_status == STATUS_OK) ? packets_seen_in : '0;
         out_words_ff   <= (result_status == STATUS_OK) ? words_seen_in : '0;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.packet_count = out_packets_ff;
   assign rsp_ch.word_count   = out_words_ff;

endmodule

[design/t7csv_checker.sv]
// Port-level assertions for the type-7 stream validator, bound to its top level.
// Depends on t7csv_pkg and type7_command_stream_validator_unit_assert.svh.
`include "type7_command_stream_validator_unit_assert.svh"

module t7csv_checker
   import t7csv_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_packet_count,
   input logic [COUNT_W-1:0]  rsp_word_count
);

   // A faulted stream reports no counts.
   `T7CSV_ASSERT_SAME(a_fault_zero_counts, rsp_valid && rsp_status != STATUS_OK, rsp_packet_count == '0 && rsp_word_count == '0, "faulted response carries nonzero counts")

   // A clean stream has at least its final word, and no more packets than words.
   `T7CSV_ASSERT_SAME(a_ok_counts, rsp_valid && rsp_status == STATUS_OK, rsp_word_count != '0 && rsp_packet_count <= rsp_word_count, "inconsistent counts on a clean response")

   // Counts never pass the saturation bound.
   `T7CSV_ASSERT_SAME(a_count_bound, rsp_valid, rsp_packet_count <= COUNT_LIMIT && rsp_word_count <= COUNT_LIMIT, "response count above the bound")

   // A stalled response stays valid with its status and word count held.
   `T7CSV_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_word_count), "stalled response changed")

endmodule

bind type7_command_stream_validator_unit t7csv_checker u_t7csv_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_packet_count (rsp_ch.packet_count),
   .rsp_word_count   (rsp_ch.word_count)
);

[tb/t7csv_tb_pkg.sv]
// Scoreboard for the type-7 command stream validator testbench.
// Depends on t7csv_pkg for field widths, header constants and status codes.
package t7csv_tb_pkg;
   import t7csv_pkg::*;

   // One stream summary as the block reports it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  packet_count;
      logic [COUNT_W-1:0]  word_count;
   } stream_summary_type;

   class stream_scoreboard;
      logic [LEN_W-1:0]    skip_left;
      logic [COUNT_W-1:0]  nop_packets;
      logic [COUNT_W-1:0]  stream_words;
      logic [STATUS_W-1:0] first_fault;
      logic                opcode_fault_armed;
      stream_summary_type  summaries[$];
      int unsigned         mismatches;

      function new();
         clear_stream();
         mismatches = 0;
      endfunction

      // Every stream starts from a clean slate.
      function void clear_stream();
         skip_left          = '0;
         nop_packets        = '0;
         stream_words       = '0;
         first_fault        = STATUS_OK;
         opcode_fault_armed = 1'b0;
      endfunction

      function int unsigned pending();
         return summaries.size();
      endfunction

      // Counters stop at the stream bound instead of wrapping.
      function logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
         return (v < COUNT_LIMIT) ? v + COUNT_W'(1) : COUNT_LIMIT;
      endfunction

      // Type nibble, reserved nibble and both odd-parity bits must agree.
      function bit header_valid(input logic [WORD_W-1:0] w);
         logic [OP_W-1:0]  op;
         logic [LEN_W-1:0] len;
         op  = w[22:16];
         len = w[13:0];
         return w[31:28] == HDR_TYPE_VALUE && w[27:24] == HDR_RSVD_VALUE &&
                w[23] == ~^op && w[15] == ~^len;
      endfunction

      // Advances the predicted state by one accepted request.
      function void note_request(input logic [WORD_W-1:0] w, input logic last);
         stream_summary_type s;
         if (first_fault == STATUS_OK) begin
            stream_words = bump(stream_words);
            if (skip_left != '0) begin
               skip_left = skip_left - LEN_W'(1);
               // A wrong opcode only counts once its payload is complete.
               if (skip_left == '0 && opcode_fault_armed) begin
                  first_fault        = STATUS_BAD_OPCODE;
                  opcode_fault_armed = 1'b0;
               end
            end else if (!header_valid(w)) begin
               first_fault = STATUS_BAD_HEADER;
            end else begin
               skip_left = w[13:0];
               if (w[22:16] != OP_NOP) begin
                  if (w[13:0] == '0) begin
                     first_fault = STATUS_BAD_OPCODE;
                  end else begin
                     opcode_fault_armed = 1'b1;
                  end
               end else begin
                  nop_packets = bump(nop_packets);
               end
            end
         end
         if (last) begin
            s.status = first_fault;
            // Ending inside a payload overrides a pending opcode fault.
            if (s.status == STATUS_OK && skip_left != '0) begin
               s.status = STATUS_OVERRUN;
            end
            s.packet_count = (s.status == STATUS_OK) ? nop_packets : '0;
            s.word_count   = (s.status == STATUS_OK) ? stream_words : '0;
            summaries.push_back(s);
            clear_stream();
         end
      endfunction

      // Compares one accepted result with the oldest predicted summary.
      function void check_result(input stream_summary_type got);
         stream_summary_type want;
         if (summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: status %0d packets %0d words %0d",
                        got.status, got.packet_count, got.word_count);
            end
            return;
         end
         want = summaries.pop_front();
         if (got.status != want.status || got.packet_count != want.packet_count ||
             got.word_count != want.word_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch: expected status %0d packets %0d words %0d, %s",
                        want.status, want.packet_count, want.word_count,
                        $sformatf("got status %0d packets %0d words %0d",
                                  got.status, got.packet_count, got.word_count));
            end
         end
      endfunction
   endclass

endpackage

[tb/type7_command_stream_validator_unit_tb.sv]
// Top level testbench of the type-7 command stream validator: directed and random streams.
// Depends on t7csv_pkg, the channel interfaces, t7csv_tb_pkg and the block itself.
module type7_command_stream_validator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import t7csv_pkg::*;
   import t7csv_tb_pkg::*;

   localparam int unsigned RANDOM_WORDS = 400;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef enum int {FLAW_TYPE, FLAW_RSVD, FLAW_OP_PARITY, FLAW_LEN_PARITY} header_flaw_type;

   logic clock;
   logic reset;
   int unsigned cycles = 0;
   int unsigned words_sent = 0;
   int unsigned send_idle;
   int unsigned recv_idle;
   logic [WORD_W-1:0] stream_q[$];
   stream_scoreboard board;

   t7csv_req_if req_ch();
   t7csv_rsp_if rsp_ch();

   type7_command_stream_validator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 20 ns clock.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("type7_command_stream_validator_unit_tb: errors");
         $finish;
      end
   end

   // The result side stalls at random.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Results are checked at the edge that takes them.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result({rsp_ch.status, rsp_ch.packet_count, rsp_ch.word_count});
      end
   end

   // A well-formed header; bit 14 is unchecked, so it is left random.
   function automatic logic [WORD_W-1:0] make_header(input logic [OP_W-1:0] op,
                                                     input logic [LEN_W-1:0] len);
      logic [WORD_W-1:0] w;
      w        = '0;
      w[31:28] = HDR_TYPE_VALUE;
      w[27:24] = HDR_RSVD_VALUE;
      w[23]    = ~^op;
      w[22:16] = op;
      w[15]    = ~^len;
      w[14]    = 1'($urandom_range(0, 1));
      w[13:0]  = len;
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] corrupt_header(input logic [WORD_W-1:0] w,
                                                        input header_flaw_type flaw);
      case (flaw)
         FLAW_TYPE: begin
            do w[31:28] = 4'($urandom); while (w[31:28] == HDR_TYPE_VALUE);
         end
         FLAW_RSVD:      w[27:24] = 4'($urandom_range(1, 15));
         FLAW_OP_PARITY: w[23] = ~w[23];
         default:        w[15] = ~w[15];
      endcase
      return w;
   endfunction

   function automatic logic [OP_W-1:0] wrong_opcode();
      logic [OP_W-1:0] op;
      do op = OP_W'($urandom); while (op == OP_NOP);
      return op;
   endfunction

   // Mostly short payloads, now and then a longer one.
   function automatic int unsigned payload_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
   endfunction

   function automatic void add_payload(input int unsigned n);
      repeat (n) stream_q.push_back($urandom);
   endfunction

   function automatic void add_packet(input logic [OP_W-1:0] op, input int unsigned len);
      stream_q.push_back(make_header(op, LEN_W'(len)));
      add_payload(len);
   endfunction

   // Offers one request after a random gap and waits until it is taken.
   task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid    <= 1'b0;
         req_ch.cmd_word <= $urandom;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd_word      <= w;
      req_ch.end_of_stream <= last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(w, last);
      words_sent++;
      @(negedge clock);
   endtask

   // Sends the queued words with the end flag on the final one.
   task automatic send_stream();
      int unsigned n;
      n = stream_q.size();
      for (int unsigned i = 0; i < n; i++) begin
         send_word(stream_q[i], i == n - 1);
      end
      stream_q.delete();
   endtask

   // Directed streams: extremes, each header flaw and each fault ordering.
   task automatic directed_streams();
      // Lone NOP header with no payload.
      add_packet(OP_NOP, 0);
      send_stream();
      // NOP with all-ones and all-zeros payload words.
      stream_q.push_back(make_header(OP_NOP, LEN_W'(2)));
      stream_q.push_back(32'hffff_ffff);
      stream_q.push_back(32'h0000_0000);
      send_stream();
      // Each way a header can be malformed; words after the fault are ignored.
      for (int f = FLAW_TYPE; f <= FLAW_LEN_PARITY; f++) begin
         stream_q.push_back(corrupt_header(make_header(OP_NOP, '0), header_flaw_type'(f)));
         if (f == FLAW_RSVD) begin
            stream_q.push_back(make_header(OP_NOP, '0));
         end
         send_stream();
      end
      // Wrong opcode without payload faults at once.
      add_packet(7'h7f, 0);
      send_stream();
      // Wrong opcode whose payload completes.
      add_packet(7'h00, 1);
      send_stream();
      // Wrong opcode cut short: the overrun wins.
      stream_q.push_back(make_header(7'h11, LEN_W'(2)));
      add_payload(1);
      send_stream();
      // Largest payload count with the stream ending on the header.
      stream_q.push_back(make_header(OP_NOP, 14'h3fff));
      send_stream();
   endtask

   // One random stream; most are well formed, the rest carry one kind of fault.
   task automatic random_stream();
      int unsigned pick;
      int unsigned len;
      int unsigned lead;
      logic [OP_W-1:0] op;
      pick = $urandom_range(0, 99);
      lead = (pick < 60) ? $urandom_range(1, 4) : $urandom_range(0, 2);
      repeat (lead) add_packet(OP_NOP, payload_length());
      if (pick < 60) begin
      end else if (pick < 68) begin
         add_packet(wrong_opcode(), $urandom_range(1, 4));
         add_payload($urandom_range(0, 3));
      end else if (pick < 74) begin
         add_packet(wrong_opcode(), 0);
         add_payload($urandom_range(0, 3));
      end else if (pick < 82) begin
         // Stream ends inside a payload.
         len = ($urandom_range(0, 3) == 0) ? 14'h3fff : $urandom_range(1, 20);
         op  = $urandom_range(0, 1) ? OP_NOP : wrong_opcode();
         stream_q.push_back(make_header(op, LEN_W'(len)));
         add_payload($urandom_range(0, (len > 20) ? 20 : len - 1));
      end else if (pick < 92) begin
         stream_q.push_back(corrupt_header(make_header(OP_W'($urandom), LEN_W'($urandom)),
                                           header_flaw_type'($urandom_range(0, 3))));
         add_payload($urandom_range(0, 3));
      end else begin
         add_payload($urandom_range(1, 4));
      end
      send_stream();
   endtask

   initial begin
      int unsigned start;
      board                = new();
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.cmd_word      = '0;
      req_ch.end_of_stream = 1'b0;
      rsp_ch.ready         = 1'b0;
      send_idle            = 17;
      recv_idle            = 62;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_streams();

      // Idling shifts from the receiver to the sender, then stops.
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         if (words_sent - start >= 2 * RANDOM_WORDS / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (words_sent - start >= RANDOM_WORDS / 3) begin
            send_idle = 62;
            recv_idle = 17;
         end
         random_stream();
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding results, then allow for the pipeline depth.
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("type7_command_stream_validator_unit_tb: clean");
      end else begin
         $display("type7_command_stream_validator_unit_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/t7csv_pkg.sv
design/t7csv_stream_if.sv
design/type7_command_stream_validator_unit.sv
design/t7csv_checker.sv
tb/t7csv_tb_pkg.sv
tb/type7_command_stream_validator_unit_tb.sv
